### rtl/ocpu_pkg.sv
// Shared types and constants for the off-CPU time accumulator.
`timescale 1ns / 1ps
package ocpu_pkg;
  localparam int ID_W      = 23;
  localparam int IDS_W     = 2 * ID_W;
  localparam int US_W      = 55;
  localparam int NS_PER_US = 1000;
  localparam int DEF_START_ENTRIES = 1024;
  localparam int DEF_COUNT_ENTRIES = 1024;

  typedef struct packed {
    logic [ID_W-1:0] out_thread;
    logic [ID_W-1:0] out_process;
    logic [ID_W-1:0] in_thread;
    logic [ID_W-1:0] in_process;
    logic [63:0]     now_ns;
    logic [63:0]     user_stack;
    logic [63:0]     kernel_stack;
    logic [63:0]     name_low;
    logic [63:0]     name_high;
  } in_t;

  typedef struct packed {
    logic            start_recorded;
    logic            start_dropped;
    logic            time_added;
    logic            counter_dropped;
    logic [US_W-1:0] interval_us;
    logic [63:0]     total_us;
  } out_t;

  typedef struct packed {
    logic [IDS_W-1:0] ids;
    logic [63:0]      stamp;
    logic [63:0]      user_stack;
    logic [63:0]      kernel_stack;
    logic [63:0]      name_low;
    logic [63:0]      name_high;
  } srec_t;

  typedef struct packed {
    logic [IDS_W-1:0] ids;
    logic [63:0]      user_stack;
    logic [63:0]      kernel_stack;
    logic [63:0]      name_low;
    logic [63:0]      name_high;
    logic [63:0]      total;
  } crec_t;
endpackage

### rtl/offcpu_time_accumulator.sv
// Off-CPU time accumulator: start table, counter table, interval divider.
// Each entry scan of the start and counter tables is a read and a compare.
// Throughput: one event at a time; busy stays high through the strobe cycle.
// The divider converts the measured interval from ns to us once it is found.
// Reset (synchronous, rst_n low) empties both tables via fill counters; no clearing pass.
`timescale 1ns / 1ps
module offcpu_time_accumulator #(
  parameter int START_ENTRIES = ocpu_pkg::DEF_START_ENTRIES,
  parameter int COUNT_ENTRIES = ocpu_pkg::DEF_COUNT_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  ocpu_pkg::in_t             in_data,
  output logic                      out_strobe,
  output ocpu_pkg::out_t            out_data,
  input  logic                      cfg_we,
  input  logic [ocpu_pkg::ID_W-1:0] cfg_data
);
  localparam int SAW = $clog2(START_ENTRIES);
  localparam int SFW = $clog2(START_ENTRIES + 1);
  localparam int CAW = $clog2(COUNT_ENTRIES);
  localparam int CFW = $clog2(COUNT_ENTRIES + 1);

  typedef enum logic [3:0] {
    IDLE, S_RQ, S_CMP, S_WR, E_BEGIN, E_RQ, E_CMP, DIV, C_BEGIN, C_RQ, C_CMP, C_WR, DONE
  } state_t;

  state_t state_r;
  logic [ocpu_pkg::ID_W-1:0] watch_r;
  ocpu_pkg::in_t  in_r;
  ocpu_pkg::out_t res_r;

  ocpu_pkg::srec_t smem [START_ENTRIES];
  ocpu_pkg::crec_t cmem [COUNT_ENTRIES];
  ocpu_pkg::srec_t srd_r, shit_r, swdata;
  ocpu_pkg::crec_t crd_r, cwdata;
  logic [SAW-1:0] sptr_r;
  logic [CAW-1:0] cptr_r;
  logic [SFW-1:0] sfill_r, sidx_r;
  logic [CFW-1:0] cfill_r;
  logic           s_we, c_we;
  logic [SAW-1:0] s_waddr;
  logic [CAW-1:0] c_waddr;
  logic           cfound_r;
  logic [63:0]    total_nxt;

  logic        div_go;
  logic        div_done;
  logic [63:0] div_q;

  logic [ocpu_pkg::IDS_W-1:0] out_ids, in_ids;
  logic start_part, end_part, ckey_hit;

  assign out_ids    = {in_r.out_thread, in_r.out_process};
  assign in_ids     = {in_r.in_thread, in_r.in_process};
  assign start_part = (in_data.out_process != '0) && (in_data.out_process == watch_r);
  assign end_part   = (in_r.in_thread != '0) && (in_r.in_process != '0)
                      && (in_r.in_process == watch_r);
  assign ckey_hit   = (crd_r.ids == in_ids) && (crd_r.user_stack == shit_r.user_stack)
                      && (crd_r.kernel_stack == shit_r.kernel_stack)
                      && (crd_r.name_low == shit_r.name_low)
                      && (crd_r.name_high == shit_r.name_high);

  assign swdata = '{ids: out_ids, stamp: in_r.now_ns, user_stack: in_r.user_stack,
                    kernel_stack: in_r.kernel_stack, name_low: in_r.name_low,
                    name_high: in_r.name_high};
  assign total_nxt = cfound_r ? crd_r.total + {9'd0, res_r.interval_us}
                              : {9'd0, res_r.interval_us};
  assign cwdata = '{ids: in_ids, user_stack: shit_r.user_stack,
                    kernel_stack: shit_r.kernel_stack, name_low: shit_r.name_low,
                    name_high: shit_r.name_high, total: total_nxt};

  assign s_we    = (state_r == S_WR) && (sidx_r != SFW'(START_ENTRIES));
  assign s_waddr = sidx_r[SAW-1:0];
  assign c_we    = (state_r == C_WR) && (cfound_r || (cfill_r != CFW'(COUNT_ENTRIES)));
  assign c_waddr = cfound_r ? cptr_r : cfill_r[CAW-1:0];
  assign div_go  = (state_r == E_CMP) && (srd_r.ids == in_ids);

  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr] <= swdata;
    srd_r <= smem[sptr_r];
  end

  always_ff @(posedge clk) begin
    if (c_we) cmem[c_waddr] <= cwdata;
    crd_r <= cmem[cptr_r];
  end

  ocpu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (in_r.now_ns - srd_r.stamp),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      watch_r <= '0;
      sfill_r <= '0;
      cfill_r <= '0;
    end else begin
      if (cfg_we) watch_r <= cfg_data;
      case (state_r)
        IDLE: begin
          if (start) begin
            in_r   <= in_data;
            res_r  <= '0;
            sptr_r <= '0;
            if (!start_part) state_r <= E_BEGIN;
            else if (sfill_r == '0) begin
              sidx_r  <= sfill_r;
              state_r <= S_WR;
            end else state_r <= S_RQ;
          end
        end
        S_RQ: state_r <= S_CMP;
        S_CMP: begin
          if (srd_r.ids == out_ids) begin
            sidx_r  <= SFW'(sptr_r);
            state_r <= S_WR;
          end else if (SFW'(sptr_r) + SFW'(1) == sfill_r) begin
            sidx_r  <= sfill_r;
            state_r <= S_WR;
          end else begin
            sptr_r  <= sptr_r + SAW'(1);
            state_r <= S_RQ;
          end
        end
        S_WR: begin
          if (s_we) begin
            res_r.start_recorded <= 1'b1;
            if (sidx_r == sfill_r) sfill_r <= sfill_r + SFW'(1);
          end else res_r.start_dropped <= 1'b1;
          state_r <= E_BEGIN;
        end
        E_BEGIN: begin
          sptr_r <= '0;
          if (end_part && (sfill_r != '0)) state_r <= E_RQ;
          else state_r <= DONE;
        end
        E_RQ: state_r <= E_CMP;
        E_CMP: begin
          if (srd_r.ids == in_ids) begin
            shit_r  <= srd_r;
            state_r <= DIV;
          end else if (SFW'(sptr_r) + SFW'(1) == sfill_r) state_r <= DONE;
          else begin
            sptr_r  <= sptr_r + SAW'(1);
            state_r <= E_RQ;
          end
        end
        DIV: begin
          if (div_done) begin
            res_r.interval_us <= div_q[ocpu_pkg::US_W-1:0];
            state_r <= C_BEGIN;
          end
        end
        C_BEGIN: begin
          cptr_r   <= '0;
          cfound_r <= 1'b0;
          if (cfill_r == '0) state_r <= C_WR;
          else state_r <= C_RQ;
        end
        C_RQ: state_r <= C_CMP;
        C_CMP: begin
          if (ckey_hit) begin
            cfound_r <= 1'b1;
            state_r  <= C_WR;
          end else if (CFW'(cptr_r) + CFW'(1) == cfill_r) state_r <= C_WR;
          else begin
            cptr_r  <= cptr_r + CAW'(1);
            state_r <= C_RQ;
          end
        end
        C_WR: begin
          if (c_we) begin
            res_r.time_added <= 1'b1;
            res_r.total_us   <= total_nxt;
            if (!cfound_r) cfill_r <= cfill_r + CFW'(1);
          end else res_r.counter_dropped <= 1'b1;
          state_r <= DONE;
        end
        DONE: state_r <= IDLE;
        default: state_r <= IDLE;
      endcase
    end
  end

  assign busy       = (state_r != IDLE);
  assign out_strobe = (state_r == DONE);
  assign out_data   = res_r;

`ifndef SYNTHESIS
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe longer than one cycle");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (sfill_r <= SFW'(START_ENTRIES)) && (cfill_r <= CFW'(COUNT_ENTRIES)))
    else $error("table fill beyond depth");
  a_start_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_data.start_recorded && out_data.start_dropped))
    else $error("start both recorded and dropped");
  a_count_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_data.time_added && out_data.counter_dropped))
    else $error("counter both added and dropped");
`endif
endmodule

### rtl/ocpu_div.sv
// Interval divider: 64-bit value by the ns-per-us constant, one 16-bit digit per cycle.
`timescale 1ns / 1ps
module ocpu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] dividend,
  output logic        done,
  output logic [63:0] quotient
);
  localparam int RW = $clog2(ocpu_pkg::NS_PER_US);
  localparam int DW = 16;
  localparam int XW = RW + DW;
  localparam int SH = XW + RW;
  localparam int MW = SH - RW + 1;
  // ceil(2^SH / divisor): exact for every XW-bit partial dividend
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(ocpu_pkg::NS_PER_US) - 64'd1)
                                  / 64'(ocpu_pkg::NS_PER_US);

  logic [RW-1:0]    rem_r, rem_nxt;
  logic [63:0]      q_r, q_nxt;
  logic [1:0]       cnt_r;
  logic             run_r, done_r;
  logic [XW-1:0]    x, back, diff;
  logic [XW+MW-1:0] prod;
  logic [DW-1:0]    qd;

  always_comb begin
    x       = {rem_r, q_r[63:64-DW]};
    prod    = {{MW{1'b0}}, x} * {{XW{1'b0}}, RECIP[MW-1:0]};
    qd      = prod[SH+DW-1:SH];
    back    = XW'(qd) * XW'(ocpu_pkg::NS_PER_US);
    diff    = x - back;
    rem_nxt = diff[RW-1:0];
    q_nxt   = {q_r[63-DW:0], qd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        q_r   <= dividend;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule
